@@ src/rcnh_pkg.sv @@
// ----------------------------------------------------------------------------
// rcnh_pkg
// Shared constants for the ray/circle nearest-hit core: fixed field widths,
// the far distance and the configuration register map.
// ----------------------------------------------------------------------------
`default_nettype none

package rcnh_pkg;

  // Direction registers are signed Q1.14 in 16 bits
  localparam int DIR_W  = 16;
  // Running distance, unsigned Q14.8
  localparam int DIST_W = 22;

  // 10000.0 in Q14.8
  localparam logic [DIST_W-1:0] FAR_DIST = 22'd2560000;

  // Reset direction: +1.0 along x
  localparam logic signed [DIR_W-1:0] DIR_X_RESET = 16'sd16384;
  localparam logic signed [DIR_W-1:0] DIR_Y_RESET = 16'sd0;

  // Configuration register map
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_X = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_Y = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DIR_X    = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_DIR_Y    = 2'd3;

  // Output sideband bit positions
  typedef struct packed {
    logic mark_enemy_hit;
    logic became_nearest;
    logic circle_hit;
  } out_flags_t;

endpackage

`default_nettype wire

@@ src/ray_circle_nearest_hit_core.sv @@
// ----------------------------------------------------------------------------
// ray_circle_nearest_hit_core
// Casts one ray against a stream of circles and tracks the nearest hit and
// its end point, using one shared multiplier and a bit-serial square root.
// ----------------------------------------------------------------------------
`default_nettype none

// The ray (origin, direction) must be set through the cfg write channel only
// while the core is idle; the core does not enforce this. Circles then stream
// in on s_*, one word per circle, with tlast on the final circle of the ray.
// Every circle gives one result word on m_*, carrying the running nearest
// distance and end point; after the tlast word the nearest distance goes back
// to 10000.0. Each circle passes through the product, check, nearest and end
// point states, and through the square root states when the discriminant is
// not negative: all products go through a single multiplier one after the
// other, and the floor square root retires one root bit per cycle. The input
// side is not ready while a circle is in work and takes the next circle in
// the cycle after the result is loaded; a finished result waits in the output
// register while the next circle is accepted.
module ray_circle_nearest_hit_core #(
  parameter int COORD_WIDTH   = 24,
  parameter int DIR_FRAC_BITS = 14
) (
  input  wire                                           clk,
  input  wire                                           rst,
  // cfg write channel
  input  wire                                           cfg_valid,
  output logic                                          cfg_ready,
  input  wire  [rcnh_pkg::CFG_IDX_W-1:0]                cfg_index,
  input  wire  [COORD_WIDTH-1:0]                        cfg_data,
  // circle stream in
  input  wire                                           s_tvalid,
  output logic                                          s_tready,
  // tdata: center_x, center_y, circle_radius, zero pad
  input  wire  [((3*COORD_WIDTH-1+7)/8)*8-1:0]          s_tdata,
  // tuser: is_enemy
  input  wire                                           s_tuser,
  input  wire                                           s_tlast,
  // result stream out
  output logic                                          m_tvalid,
  input  wire                                           m_tready,
  // tdata: nearest_dist, end_x, end_y, zero pad
  output logic [((rcnh_pkg::DIST_W+2*COORD_WIDTH+7)/8)*8-1:0] m_tdata,
  // tuser: circle_hit, became_nearest, mark_enemy_hit
  output logic [2:0]                                    m_tuser,
  output logic                                          m_tlast
);
  import rcnh_pkg::*;

  // Widths derived from the coordinate and direction formats
  localparam int C_W    = COORD_WIDTH;
  localparam int R_W    = COORD_WIDTH - 1;
  localparam int OUT_W  = ((DIST_W+2*C_W+7)/8)*8;
  localparam int M_W    = C_W + 1;
  localparam int DOT_W  = M_W + DIR_W + 1;
  localparam int B_W    = DOT_W - DIR_FRAC_BITS;
  localparam int OP_W   = (B_W > DIST_W + 1) ? B_W : DIST_W + 1;
  localparam int ACC_W  = 2*OP_W + 2;
  localparam int ROOT_W = ACC_W / 2;
  localparam int REM_W  = ROOT_W + 2;
  localparam int CNT_W  = $clog2(ROOT_W);
  localparam int T_W    = ((B_W > ROOT_W) ? B_W : ROOT_W) + 2;
  localparam int SUM_W  = ACC_W + 1;

  // Sequencer codes
  localparam logic [3:0] ST_IDLE = 4'd0;
  localparam logic [3:0] ST_MXD  = 4'd1;
  localparam logic [3:0] ST_MYD  = 4'd2;
  localparam logic [3:0] ST_MXX  = 4'd3;
  localparam logic [3:0] ST_MYY  = 4'd4;
  localparam logic [3:0] ST_RR   = 4'd5;
  localparam logic [3:0] ST_BB   = 4'd6;
  localparam logic [3:0] ST_CHK  = 4'd7;
  localparam logic [3:0] ST_SQRT = 4'd8;
  localparam logic [3:0] ST_ROOT = 4'd9;
  localparam logic [3:0] ST_BEST = 4'd10;
  localparam logic [3:0] ST_EX   = 4'd11;
  localparam logic [3:0] ST_EY   = 4'd12;
  localparam logic [3:0] ST_DONE = 4'd13;

  // Configuration registers
  logic signed [C_W-1:0]   origin_x;
  logic signed [C_W-1:0]   origin_y;
  logic signed [DIR_W-1:0] dir_x;
  logic signed [DIR_W-1:0] dir_y;

  // Control state
  logic [3:0]        state;
  logic [DIST_W-1:0] best;
  logic              out_valid;

  // Work registers
  logic signed [M_W-1:0]   mx;
  logic signed [M_W-1:0]   my;
  logic [R_W-1:0]          rad;
  logic                    enemy;
  logic                    last;
  logic signed [ACC_W-1:0] acc;
  logic signed [B_W-1:0]   b;
  logic [ACC_W-1:0]        sq_src;
  logic [REM_W-1:0]        sq_rem;
  logic [ROOT_W-1:0]       sq_root;
  logic [CNT_W-1:0]        sq_cnt;
  logic signed [T_W-1:0]   t_val;
  logic                    hit;
  logic                    nearer;
  logic signed [C_W-1:0]   end_x;
  logic signed [C_W-1:0]   end_y;

  // Output registers
  logic [OUT_W-1:0] out_data;
  out_flags_t       out_flags;
  logic             out_last;

  // Shared multiplier
  logic signed [OP_W-1:0]   mul_a;
  logic signed [OP_W-1:0]   mul_b;
  logic signed [2*OP_W-1:0] prod;

  // Combinational helpers
  logic signed [C_W-1:0]   in_cx;
  logic signed [C_W-1:0]   in_cy;
  logic [REM_W-1:0]        rem_sh;
  logic [REM_W-1:0]        trial;
  logic signed [T_W-1:0]   neg_b;
  logic signed [T_W-1:0]   t_near;
  logic signed [T_W-1:0]   t_far;
  logic signed [T_W-1:0]   best_ext;
  logic                    in_acc;
  logic                    out_free;
  logic signed [SUM_W-1:0] end_x_sum;
  logic signed [SUM_W-1:0] end_y_sum;

  // Clamp a wide sum to the signed coordinate range
  function automatic logic signed [C_W-1:0] sat_coord(input logic signed [SUM_W-1:0] v);
    logic signed [SUM_W-1:0] hi;
    logic signed [SUM_W-1:0] lo;
    hi = SUM_W'((SUM_W'(1) <<< (C_W-1)) - SUM_W'(1));
    lo = -hi - SUM_W'(1);
    if (v > hi) begin
      sat_coord = C_W'(hi);
    end else if (v < lo) begin
      sat_coord = C_W'(lo);
    end else begin
      sat_coord = C_W'(v);
    end
  endfunction

  // Nearer test: a real hit strictly below the running nearest
  function automatic logic nearer_now();
    nearer_now = hit && (t_val < best_ext);
  endfunction

  assign cfg_ready = !rst;
  assign s_tready  = !rst && (state == ST_IDLE);
  assign in_acc    = s_tvalid && s_tready;
  assign out_free  = !out_valid || m_tready;

  assign in_cx = s_tdata[C_W-1:0];
  assign in_cy = s_tdata[2*C_W-1:C_W];

  // Operand select for the shared multiplier
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state)
      ST_MXD: begin
        mul_a = OP_W'(mx);
        mul_b = OP_W'(dir_x);
      end
      ST_MYD: begin
        mul_a = OP_W'(my);
        mul_b = OP_W'(dir_y);
      end
      ST_MXX: begin
        mul_a = OP_W'(mx);
        mul_b = OP_W'(mx);
      end
      ST_MYY: begin
        mul_a = OP_W'(my);
        mul_b = OP_W'(my);
      end
      ST_RR: begin
        mul_a = OP_W'(rad);
        mul_b = OP_W'(rad);
      end
      ST_BB: begin
        mul_a = OP_W'(b);
        mul_b = OP_W'(b);
      end
      ST_EX: begin
        mul_a = OP_W'(dir_x);
        mul_b = OP_W'(best);
      end
      ST_EY: begin
        mul_a = OP_W'(dir_y);
        mul_b = OP_W'(best);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign prod = mul_a * mul_b;

  // One square root step: bring down two bits, try root*4+1
  assign rem_sh = {sq_rem[ROOT_W-1:0], sq_src[ACC_W-1 -: 2]};
  assign trial  = {sq_root, 2'b01};

  // Roots of the quadratic: near root first, far root if near is negative
  assign neg_b    = -T_W'(b);
  assign t_near   = neg_b - T_W'(sq_root);
  assign t_far    = neg_b + T_W'(sq_root);
  assign best_ext = T_W'(best);

  // End point: origin + floor(dir * best / 2^F)
  assign end_x_sum = SUM_W'(acc >>> DIR_FRAC_BITS) + SUM_W'(origin_x);
  assign end_y_sum = SUM_W'(acc >>> DIR_FRAC_BITS) + SUM_W'(origin_y);

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      origin_x <= '0;
      origin_y <= '0;
      dir_x    <= DIR_X_RESET;
      dir_y    <= DIR_Y_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_ORIGIN_X: origin_x <= cfg_data;
        REG_ORIGIN_Y: origin_y <= cfg_data;
        REG_DIR_X:    dir_x    <= cfg_data[DIR_W-1:0];
        REG_DIR_Y:    dir_y    <= cfg_data[DIR_W-1:0];
        default:      ;
      endcase
    end
  end

  // Sequencer and control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      best      <= FAR_DIST;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && m_tready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (in_acc) begin
            state <= ST_MXD;
          end
        end
        ST_MXD:  state <= ST_MYD;
        ST_MYD:  state <= ST_MXX;
        ST_MXX:  state <= ST_MYY;
        ST_MYY:  state <= ST_RR;
        ST_RR:   state <= ST_BB;
        ST_BB:   state <= ST_CHK;
        ST_CHK: begin
          state <= acc[ACC_W-1] ? ST_BEST : ST_SQRT;
        end
        ST_SQRT: begin
          if (sq_cnt == '0) begin
            state <= ST_ROOT;
          end
        end
        ST_ROOT: state <= ST_BEST;
        ST_BEST: begin
          if (nearer_now()) begin
            best <= DIST_W'(t_val);
          end
          state <= ST_EX;
        end
        ST_EX:   state <= ST_EY;
        ST_EY:   state <= ST_DONE;
        ST_DONE: begin
          if (out_free) begin
            out_valid <= 1'b1;
            if (last) begin
              best <= FAR_DIST;
            end
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    unique case (state)
      ST_IDLE: begin
        if (in_acc) begin
          mx    <= M_W'(origin_x) - M_W'(in_cx);
          my    <= M_W'(origin_y) - M_W'(in_cy);
          rad   <= s_tdata[3*C_W-2:2*C_W];
          enemy <= s_tuser;
          last  <= s_tlast;
          hit   <= 1'b0;
        end
      end
      ST_MXD: acc <= ACC_W'(prod);
      ST_MYD: acc <= acc + ACC_W'(prod);
      ST_MXX: begin
        b   <= B_W'(acc >>> DIR_FRAC_BITS);
        acc <= ACC_W'(prod);
      end
      ST_MYY: acc <= acc + ACC_W'(prod);
      ST_RR:  acc <= acc - ACC_W'(prod);
      ST_BB:  acc <= ACC_W'(prod) - acc;
      ST_CHK: begin
        sq_src  <= acc;
        sq_rem  <= '0;
        sq_root <= '0;
        sq_cnt  <= CNT_W'(ROOT_W - 1);
      end
      ST_SQRT: begin
        if (rem_sh >= trial) begin
          sq_rem  <= rem_sh - trial;
          sq_root <= {sq_root[ROOT_W-2:0], 1'b1};
        end else begin
          sq_rem  <= rem_sh;
          sq_root <= {sq_root[ROOT_W-2:0], 1'b0};
        end
        sq_src <= sq_src << 2;
        sq_cnt <= sq_cnt - CNT_W'(1);
      end
      ST_ROOT: begin
        t_val <= t_near[T_W-1] ? t_far : t_near;
        hit   <= t_near[T_W-1] ? !t_far[T_W-1] : 1'b1;
      end
      ST_BEST: nearer <= nearer_now();
      ST_EX:   acc <= ACC_W'(prod);
      ST_EY: begin
        end_x <= sat_coord(end_x_sum);
        acc   <= ACC_W'(prod);
      end
      ST_DONE: begin
        if (out_free) begin
          out_data  <= OUT_W'({sat_coord(end_y_sum), end_x, best});
          out_flags <= '{mark_enemy_hit: nearer && enemy,
                         became_nearest: nearer,
                         circle_hit:     hit};
          out_last  <= last;
        end
      end
      default: ;
    endcase
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = out_data;
  assign m_tuser  = out_flags;
  assign m_tlast  = out_last;

  // end_y is formed straight into the output word; end_x is kept for it
  // Checks
  a_mark_needs_nearer: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (!m_tuser[2] || m_tuser[1]))
    else $error("enemy marked hit without becoming nearest");

  a_nearer_needs_hit: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (!m_tuser[1] || m_tuser[0]))
    else $error("nearest updated without a hit");

  a_best_bounded: assert property (@(posedge clk) disable iff (rst)
    best <= FAR_DIST)
    else $error("running nearest above far distance");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> !s_tready)
    else $error("input ready while a circle is in work");

endmodule

`default_nettype wire
